// ===== rtl/tmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmhq_pkg
// Shared types and codes for the timer min-heap queue.
// ----------------------------------------------------------------------------
package tmhq_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int ID_COUNT_DEF = 1024;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_ADJUST = 3'd1;
  localparam logic [2:0] OP_FIRE   = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_POP    = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // one heap slot
  typedef struct packed {
    logic [31:0] expiry;
    logic [9:0]  owner;
  } slot_t;

endpackage

// ===== rtl/tmhq_cell.sv =====
// ----------------------------------------------------------------------------
// tmhq_cell
// One heap slot: holds expiry and owner, loads on a write addressed to it.
// ----------------------------------------------------------------------------
module tmhq_cell #(
  parameter int SW    = 5,
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [SW-1:0]   wr_idx,
  input  tmhq_pkg::slot_t wr_data,
  output tmhq_pkg::slot_t q
);

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == SW'(INDEX))) begin
      q <= wr_data;
    end
  end

endmodule

// ===== rtl/timer_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// timer_min_heap_queue
// Binary min-heap of timers ordered by expiry, with an id-to-slot map.
// ----------------------------------------------------------------------------
// Sequencing: an item looks up its id in the map and is checked; one that
// does not move the heap (clear, unknown id) goes straight to its report; a
// remove moves the last slot into the hole and resifts; a tick fires and
// removes each due timer in turn. Items are taken one at a time; the heap is
// walked level by level over the row of slot cells (registered slot-row read).
// Reset: rst (synchronous) empties the queue and the output register; the id
// map needs no clearing pass, an id is known only if its slot points back.
// ----------------------------------------------------------------------------
module timer_min_heap_queue #(
  parameter int CAPACITY = tmhq_pkg::CAPACITY_DEF,
  parameter int ID_COUNT = tmhq_pkg::ID_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // timer_id[9:0], duration_ms[40:10], now_ms[72:41], zero pad
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // fired_id[9:0], next_delay_ms[41:10], status[43:42], zero pad
  output logic        m_tuser,   // kind
  output logic        m_tlast    // last
);

  localparam int SW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // slot index
  localparam int CW  = $clog2(CAPACITY + 1);                    // count
  localparam int CXW = SW + 2;                                  // child index math
  localparam int IDW = $clog2(ID_COUNT);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOOK   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_RMST   = 4'd3;
  localparam logic [3:0] S_RMLD   = 4'd4;
  localparam logic [3:0] S_DNRD   = 4'd5;
  localparam logic [3:0] S_DNCMP  = 4'd6;
  localparam logic [3:0] S_DNEND  = 4'd7;
  localparam logic [3:0] S_UPRD   = 4'd8;
  localparam logic [3:0] S_UPCMP  = 4'd9;
  localparam logic [3:0] S_TKRD   = 4'd10;
  localparam logic [3:0] S_TKCHK  = 4'd11;
  localparam logic [3:0] S_RPRD   = 4'd12;
  localparam logic [3:0] S_RPOUT  = 4'd13;

  function automatic logic [IDW-1:0] to_idx(input logic [9:0] v);
    logic [IDW+9:0] w;
    w = {{IDW{1'b0}}, v};
    return w[IDW-1:0];
  endfunction

  // input fields
  logic [2:0]  in_op;
  logic [9:0]  in_id;
  logic [30:0] in_dur;
  logic [31:0] in_now;
  logic [32:0] in_sum;
  logic        accept;

  assign in_op  = s_tuser;
  assign in_id  = s_tdata[9:0];
  assign in_dur = s_tdata[40:10];
  assign in_now = s_tdata[72:41];
  assign in_sum = {1'b0, in_now} + {2'b0, in_dur};
  assign accept = s_tvalid && s_tready;

  // item registers
  logic [2:0]    op_q;
  logic [9:0]    id_q;
  logic          idok_q;
  logic [31:0]   now_q;
  logic [31:0]   exp_q;
  logic [SW-1:0] pos_q;

  // sequencer registers
  logic [3:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] cur_i, cur_i_next;
  tmhq_pkg::slot_t x, x_next;       // element being sifted
  logic          moved, moved_next;
  logic [1:0]    status, status_next;
  logic          is_tick, is_tick_next;

  // slot row and id map
  tmhq_pkg::slot_t cell_q [CAPACITY];
  tmhq_pkg::slot_t rd_a, rd_b;
  logic [SW-1:0]   ra, rb;
  logic            slot_we;
  logic [SW-1:0]   slot_widx;
  tmhq_pkg::slot_t slot_wd;

  logic [SW-1:0]   pos_mem [ID_COUNT];
  logic            pos_we;
  logic [IDW-1:0]  pos_wa;
  logic [SW-1:0]   pos_wd;

  // output register
  logic        out_free;
  logic        emit;
  logic        e_kind;
  logic [9:0]  e_id;
  logic [31:0] e_delay;
  logic [1:0]  e_status;
  logic        o_kind;
  logic [9:0]  o_id;
  logic [31:0] o_delay;
  logic [1:0]  o_status;
  logic        o_last;

  // sequencer comb helpers
  logic [CXW-1:0] c_idx, c1_idx, cnt_x, cur_x;
  logic           pick_b;
  tmhq_pkg::slot_t ch;
  logic [SW-1:0]  ch_idx;
  logic           known;
  logic [CW-1:0]  n_rm;
  logic [31:0]    diff;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // the slot cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    tmhq_cell #(.SW(SW), .INDEX(k)) u_cell (
      .clk     (clk),
      .wr_en   (slot_we),
      .wr_idx  (slot_widx),
      .wr_data (slot_wd),
      .q       (cell_q[k])
    );
  end

  // registered two-port read of the slot row
  always_ff @(posedge clk) begin
    rd_a <= cell_q[ra];
    rd_b <= cell_q[rb];
  end

  // id map
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (accept) begin
      pos_q <= pos_mem[to_idx(in_id)];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= in_op;
      id_q   <= in_id;
      idok_q <= (32'(in_id) < ID_COUNT);
      now_q  <= in_now;
      exp_q  <= in_sum[32] ? 32'hFFFF_FFFF : in_sum[31:0];
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    cur_i_next   = cur_i;
    x_next       = x;
    moved_next   = moved;
    status_next  = status;
    is_tick_next = is_tick;
    ra        = '0;
    rb        = '0;
    slot_we   = 1'b0;
    slot_widx = cur_i;
    slot_wd   = x;
    pos_we    = 1'b0;
    pos_wa    = to_idx(x.owner);
    pos_wd    = cur_i;
    emit      = 1'b0;
    e_kind    = tmhq_pkg::KIND_REPORT;
    e_id      = '0;
    e_delay   = '0;
    e_status  = tmhq_pkg::ST_OK;

    cnt_x  = CXW'(count);
    cur_x  = CXW'(cur_i);
    c_idx  = (cur_x << 1) + CXW'(1);
    c1_idx = c_idx + CXW'(1);
    pick_b = (c1_idx < cnt_x) && (rd_b.expiry < rd_a.expiry);
    ch     = pick_b ? rd_b : rd_a;
    ch_idx = pick_b ? c1_idx[SW-1:0] : c_idx[SW-1:0];
    n_rm   = count - CW'(1);
    diff   = rd_a.expiry - now_q;

    // an id is live only if its map entry points at a live slot it owns
    known = 1'b0;
    if (idok_q && (CW'(pos_q) < count) && (rd_a.owner == id_q)) begin
      known = 1'b1;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          status_next  = tmhq_pkg::ST_OK;
          is_tick_next = 1'b0;
          state_next   = S_LOOK;
        end
      end
      S_LOOK: begin
        ra         = pos_q;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        ra = pos_q;
        case (op_q)
          tmhq_pkg::OP_ADD, tmhq_pkg::OP_ADJUST: begin
            x_next.expiry = exp_q;
            x_next.owner  = id_q;
            moved_next    = 1'b0;
            if (!idok_q) begin
              status_next = tmhq_pkg::ST_UNKNOWN;
              state_next  = S_RPRD;
            end else if (known) begin
              cur_i_next = pos_q;
              state_next = S_DNRD;
            end else if (op_q == tmhq_pkg::OP_ADJUST) begin
              status_next = tmhq_pkg::ST_UNKNOWN;
              state_next  = S_RPRD;
            end else if (count >= CW'(CAPACITY)) begin
              status_next = tmhq_pkg::ST_FULL;
              state_next  = S_RPRD;
            end else begin
              cur_i_next = count[SW-1:0];
              count_next = count + CW'(1);
              state_next = S_DNRD;
            end
          end
          tmhq_pkg::OP_FIRE: begin
            if (!known) begin
              status_next = tmhq_pkg::ST_UNKNOWN;
              state_next  = S_RPRD;
            end else if (out_free) begin
              emit       = 1'b1;
              e_kind     = tmhq_pkg::KIND_FIRED;
              e_id       = id_q;
              cur_i_next = pos_q;
              state_next = S_RMST;
            end
          end
          tmhq_pkg::OP_TICK: begin
            is_tick_next = 1'b1;
            state_next   = S_TKRD;
          end
          tmhq_pkg::OP_CLEAR: begin
            count_next = '0;
            state_next = S_RPRD;
          end
          tmhq_pkg::OP_POP: begin
            if (count == '0) begin
              status_next = tmhq_pkg::ST_EMPTY;
              state_next  = S_RPRD;
            end else begin
              cur_i_next = '0;
              state_next = S_RMST;
            end
          end
          default: begin
            state_next = S_RPRD;
          end
        endcase
      end
      S_RMST: begin
        // last slot moves into the hole, then resifts over the shrunk heap
        count_next = n_rm;
        ra         = n_rm[SW-1:0];
        if (CW'(cur_i) < n_rm) begin
          state_next = S_RMLD;
        end else begin
          state_next = is_tick ? S_TKRD : S_RPRD;
        end
      end
      S_RMLD: begin
        x_next     = rd_a;
        moved_next = 1'b0;
        state_next = S_DNRD;
      end
      S_DNRD: begin
        ra = c_idx[SW-1:0];
        rb = c1_idx[SW-1:0];
        state_next = (c_idx < cnt_x) ? S_DNCMP : S_DNEND;
      end
      S_DNCMP: begin
        if (ch.expiry < x.expiry) begin
          slot_we    = 1'b1;
          slot_wd    = ch;
          pos_we     = 1'b1;
          pos_wa     = to_idx(ch.owner);
          cur_i_next = ch_idx;
          moved_next = 1'b1;
          state_next = S_DNRD;
        end else begin
          state_next = S_DNEND;
        end
      end
      S_DNEND: begin
        if (moved) begin
          slot_we    = 1'b1;
          pos_we     = 1'b1;
          state_next = is_tick ? S_TKRD : S_RPRD;
        end else begin
          state_next = S_UPRD;
        end
      end
      S_UPRD: begin
        ra = SW'((cur_i - SW'(1)) >> 1);
        if (cur_i == '0) begin
          slot_we    = 1'b1;
          pos_we     = 1'b1;
          state_next = is_tick ? S_TKRD : S_RPRD;
        end else begin
          state_next = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (rd_a.expiry > x.expiry) begin
          slot_we    = 1'b1;
          slot_wd    = rd_a;
          pos_we     = 1'b1;
          pos_wa     = to_idx(rd_a.owner);
          cur_i_next = SW'((cur_i - SW'(1)) >> 1);
          state_next = S_UPRD;
        end else begin
          slot_we    = 1'b1;
          pos_we     = 1'b1;
          state_next = is_tick ? S_TKRD : S_RPRD;
        end
      end
      S_TKRD: begin
        state_next = S_TKCHK;
      end
      S_TKCHK: begin
        // head is due: report it and remove it
        if ((count != '0) && (rd_a.expiry <= now_q)) begin
          if (out_free) begin
            emit       = 1'b1;
            e_kind     = tmhq_pkg::KIND_FIRED;
            e_id       = rd_a.owner;
            cur_i_next = '0;
            state_next = S_RMST;
          end
        end else begin
          state_next = S_RPOUT;
        end
      end
      S_RPRD: begin
        state_next = S_RPOUT;
      end
      S_RPOUT: begin
        if (out_free) begin
          emit     = 1'b1;
          e_status = status;
          if (count == '0) begin
            e_delay = 32'hFFFF_FFFF;
          end else if (rd_a.expiry <= now_q) begin
            e_delay = '0;
          end else begin
            e_delay = diff[31] ? 32'h7FFF_FFFF : diff;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      moved   <= 1'b0;
      is_tick <= 1'b0;
      status  <= tmhq_pkg::ST_OK;
    end else begin
      state   <= state_next;
      count   <= count_next;
      moved   <= moved_next;
      is_tick <= is_tick_next;
      status  <= status_next;
    end
    cur_i <= cur_i_next;
    x     <= x_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit) begin
      o_kind   <= e_kind;
      o_id     <= e_id;
      o_delay  <= e_delay;
      o_status <= e_status;
      o_last   <= (e_kind == tmhq_pkg::KIND_REPORT);
    end
  end

  assign m_tdata = {4'b0, o_status, o_delay, o_id};
  assign m_tuser = o_kind;
  assign m_tlast = o_last;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item taken while another is in work");

  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == tmhq_pkg::KIND_FIRED) |-> !m_tlast)
    else $error("fired item marked last");

endmodule
